@@ src/ricd_pkg.sv @@
// shared types and codes for the instruction class and condition decoder
`timescale 1ns / 1ps

package ricd_pkg;

   // instruction class codes
   localparam logic [3:0] CLS_DATAPROC = 4'd0;
   localparam logic [3:0] CLS_MRS      = 4'd1;
   localparam logic [3:0] CLS_MSR      = 4'd2;
   localparam logic [3:0] CLS_MUL      = 4'd3;
   localparam logic [3:0] CLS_MULL     = 4'd4;
   localparam logic [3:0] CLS_BRANCH   = 4'd5;
   localparam logic [3:0] CLS_BX       = 4'd6;
   localparam logic [3:0] CLS_BLOCK    = 4'd7;
   localparam logic [3:0] CLS_SINGLE   = 4'd8;
   localparam logic [3:0] CLS_HALF     = 4'd9;
   localparam logic [3:0] CLS_SWI      = 4'd10;
   localparam logic [3:0] CLS_SWAP     = 4'd11;
   localparam logic [3:0] CLS_UNDEF    = 4'd12;

   // condition field codes
   localparam logic [3:0] COND_EQ = 4'd0;
   localparam logic [3:0] COND_NE = 4'd1;
   localparam logic [3:0] COND_CS = 4'd2;
   localparam logic [3:0] COND_CC = 4'd3;
   localparam logic [3:0] COND_MI = 4'd4;
   localparam logic [3:0] COND_PL = 4'd5;
   localparam logic [3:0] COND_VS = 4'd6;
   localparam logic [3:0] COND_VC = 4'd7;
   localparam logic [3:0] COND_HI = 4'd8;
   localparam logic [3:0] COND_LS = 4'd9;
   localparam logic [3:0] COND_GE = 4'd10;
   localparam logic [3:0] COND_LT = 4'd11;
   localparam logic [3:0] COND_GT = 4'd12;
   localparam logic [3:0] COND_LE = 4'd13;
   localparam logic [3:0] COND_AL = 4'd14;
   localparam logic [3:0] COND_NV = 4'd15;

   typedef struct packed {
      logic [31:0] instruction;
      logic        flag_negative;
      logic        flag_zero;
      logic        flag_carry;
      logic        flag_overflow;
   } req_type;

   typedef struct packed {
      logic [3:0] insn_class;
      logic       cond_pass;
   } rsp_type;

endpackage

@@ src/ricd_classify.sv @@
// instruction class lookup on bits 27:20 and 7:4
`timescale 1ns / 1ps

module ricd_classify (
   input  logic [31:0] instruction,
   output logic [3:0]  insn_class
);
   import ricd_pkg::*;

   logic [7:0] hi;
   logic [3:0] lo;
   logic       dp_match;

   assign hi = instruction[27:20];
   assign lo = instruction[7:4];

   // test/compare ops without the s bit are not data processing
   always_comb begin
      dp_match = 1'b0;
      if (hi[7:6] == 2'b00) begin
         if (!(hi[4:3] == 2'b10 && !hi[0])) begin
            dp_match = hi[5] || !lo[0] || !lo[3];
         end
      end
   end

   always_comb begin
      if (dp_match) begin
         insn_class = CLS_DATAPROC;
      end else if ((hi & 8'hFB) == 8'h10 && lo == 4'h0) begin
         insn_class = CLS_MRS;
      end else if ((hi & 8'hFB) == 8'h32) begin
         insn_class = CLS_MSR;
      end else if ((hi & 8'hFB) == 8'h12 && lo == 4'h0) begin
         insn_class = CLS_MSR;
      end else if ((hi & 8'hFC) == 8'h00 && lo == 4'h9) begin
         insn_class = CLS_MUL;
      end else if ((hi & 8'hF8) == 8'h08 && lo == 4'h9) begin
         insn_class = CLS_MULL;
      end else if ((hi & 8'hE0) == 8'hA0) begin
         insn_class = CLS_BRANCH;
      end else if (hi == 8'h12 && lo == 4'h1) begin
         insn_class = CLS_BX;
      end else if ((hi & 8'hE0) == 8'h80) begin
         insn_class = CLS_BLOCK;
      end else if ((hi & 8'hC0) == 8'h40) begin
         insn_class = CLS_SINGLE;
      end else if ((hi & 8'hE0) == 8'h00
                   && (lo == 4'hB || lo == 4'hD || lo == 4'hF)) begin
         insn_class = CLS_HALF;
      end else if ((hi & 8'hF0) == 8'hF0) begin
         insn_class = CLS_SWI;
      end else if ((hi & 8'hFB) == 8'h10 && lo == 4'h9) begin
         insn_class = CLS_SWAP;
      end else begin
         insn_class = CLS_UNDEF;
      end
   end

endmodule

@@ src/ricd_cond.sv @@
// condition field evaluation against the status flags
`timescale 1ns / 1ps

module ricd_cond (
   input  logic [3:0] cond,
   input  logic       flag_n,
   input  logic       flag_z,
   input  logic       flag_c,
   input  logic       flag_v,
   output logic       pass
);
   import ricd_pkg::*;

   always_comb begin
      case (cond)
         COND_EQ: pass = flag_z;
         COND_NE: pass = !flag_z;
         COND_CS: pass = flag_c;
         COND_CC: pass = !flag_c;
         COND_MI: pass = flag_n;
         COND_PL: pass = !flag_n;
         COND_VS: pass = flag_v;
         COND_VC: pass = !flag_v;
         COND_HI: pass = flag_c && !flag_z;
         COND_LS: pass = !flag_c || flag_z;
         COND_GE: pass = (flag_n == flag_v);
         COND_LT: pass = (flag_n != flag_v);
         COND_GT: pass = !flag_z && (flag_n == flag_v);
         COND_LE: pass = flag_z || (flag_n != flag_v);
         COND_AL: pass = 1'b1;
         default: pass = 1'b0; // never condition
      endcase
   end

endmodule

@@ src/risc_insn_class_and_cond_decode.sv @@
// top level of the instruction class and condition decoder
`timescale 1ns / 1ps

// channel   ports                        transfer when
// ------    ---------------------------  ---------------------------
// request   start, busy, req_payload     start high and busy low
// result    rsp_valid, rsp_payload       rsp_valid high (one cycle)
//
// one item per cycle, sustained; busy stays low
// each item passes the input register, the decode logic and the result register, in that order
// the only path between the registers is the class table and the flag mux
// synchronous reset clears the two valid flags; payload registers are not reset
// the receiver cannot stall, so each result is shown for exactly one cycle

module risc_insn_class_and_cond_decode (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  ricd_pkg::req_type req_payload,
   output logic              rsp_valid,
   output ricd_pkg::rsp_type rsp_payload
);
   import ricd_pkg::*;

   // input stage
   req_type req_ff;
   req_type req_in;
   logic    req_valid_ff;
   logic    req_valid_in;

   // result stage
   rsp_type rsp_ff;
   rsp_type rsp_in;
   logic    rsp_valid_ff;
   logic    rsp_valid_in;

   logic [3:0] cls;
   logic       pass;

   // pure decode, never stalls
   assign busy = 1'b0;

   assign req_valid_in = start && !busy;
   assign req_in       = req_payload;

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
      end
   end

   // capture payload only on a transfer
   always_ff @(posedge clock) begin
      if (req_valid_in) begin
         req_ff <= req_in;
      end
   end

   // class lookup on the registered word
   ricd_classify u_classify (
      .instruction (req_ff.instruction),
      .insn_class  (cls)
   );

   // condition check on bits 31:28
   ricd_cond u_cond (
      .cond   (req_ff.instruction[31:28]),
      .flag_n (req_ff.flag_negative),
      .flag_z (req_ff.flag_zero),
      .flag_c (req_ff.flag_carry),
      .flag_v (req_ff.flag_overflow),
      .pass   (pass)
   );

   assign rsp_valid_in      = req_valid_ff;
   assign rsp_in.insn_class = cls;
   assign rsp_in.cond_pass  = pass;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_valid_in) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

`ifndef SYNTHESIS
   // every accepted item yields a result through the input and result registers
   a_accept_gives_result: assert property (
      @(posedge clock) disable iff (reset)
      (start && !busy) |-> ##2 rsp_valid
   ) else $error("accepted item produced no result");

   // no result without a matching accepted item
   a_no_spurious_result: assert property (
      @(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, 2)
   ) else $error("result strobe without matching transfer");

   // the never condition must not pass
   a_never_cond: assert property (
      @(posedge clock) disable iff (reset)
      (start && !busy && req_payload.instruction[31:28] == COND_NV)
         |-> ##2 !rsp_payload.cond_pass
   ) else $error("never condition reported as passing");

   // class code stays inside the defined range
   a_class_range: assert property (
      @(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_payload.insn_class <= CLS_UNDEF)
   ) else $error("class code out of range");
`endif

endmodule
